@@ rtl/core/bah_pkg.sv @@
// ----------------------------------------------------------------------------
// bah_pkg
// Shared constants, codes and helpers for the block averaged histogram.
// ----------------------------------------------------------------------------
package bah_pkg;

  localparam int MAX_BINS_DEF = 64;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NB_W       = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_OUTSIDE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_BLK = 3'd5;

  // item functions
  localparam logic [1:0] FN_POS = 2'd0;
  localparam logic [1:0] FN_BIN = 2'd1;
  localparam logic [1:0] FN_EOF = 2'd2;
  localparam logic [1:0] FN_FIN = 2'd3;

  // histogram modes (code 3 behaves as per-bin average)
  localparam logic [1:0] MODE_COUNT = 2'd0;
  localparam logic [1:0] MODE_WSUM  = 2'd1;

  // arithmetic unit widths
  localparam int DVD_W    = 64;
  localparam int DVS_W    = 32;
  localparam int SQ_IN_W  = 40;
  localparam int SQ_OUT_W = 64;
  localparam int RT_IN_W  = 64;
  localparam int RT_OUT_W = 40;

  localparam logic [47:0] S48MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] S48MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // saturate a 49-bit signed sum to 48 bits
  function automatic logic [47:0] sat48(input logic [48:0] s);
    logic [47:0] r;
    if (s[48] != s[47]) begin
      r = s[48] ? S48MIN : S48MAX;
    end else begin
      r = s[47:0];
    end
    return r;
  endfunction

  // magnitude of a 48-bit signed value, unsigned
  function automatic logic [47:0] mag48(input logic [47:0] a);
    logic [47:0] r;
    r = a[47] ? (~a + 48'd1) : a;
    return r;
  endfunction

endpackage

@@ rtl/core/bah_div.sv @@
// ----------------------------------------------------------------------------
// bah_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bah_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bah_pkg::DVD_W-1:0]    dividend,
  input  logic [bah_pkg::DVS_W-1:0]    divisor,
  output bah_pkg::unit_sts_t           sts,
  output logic [bah_pkg::DVD_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(bah_pkg::DVD_W + 1);

  logic [bah_pkg::DVS_W:0]   rem_r;
  logic [bah_pkg::DVD_W-1:0] quo_r;
  logic [bah_pkg::DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic [bah_pkg::DVS_W:0]   rem_sh;
  logic                      ge;

  assign rem_sh = {rem_r[bah_pkg::DVS_W-1:0], quo_r[bah_pkg::DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(bah_pkg::DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_r <= {quo_r[bah_pkg::DVD_W-2:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/core/bah_sq.sv @@
// ----------------------------------------------------------------------------
// bah_sq
// Q24.16 squarer, floor(m*m / 2^16), three partial products on one multiplier.
// ----------------------------------------------------------------------------
module bah_sq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bah_pkg::SQ_IN_W-1:0]   m,
  output bah_pkg::unit_sts_t            sts,
  output logic [bah_pkg::SQ_OUT_W-1:0]  sq
);

  localparam logic [1:0] PH_HH = 2'd0;
  localparam logic [1:0] PH_HL = 2'd1;
  localparam logic [1:0] PH_LL = 2'd2;

  logic [bah_pkg::SQ_IN_W-1:0]  m_r;
  logic [1:0]                   ph_r;
  logic [1:0]                   pph_r;
  logic                         iss_r;
  logic                         pv_r;
  logic                         done_r;
  logic [47:0]                  prod_r;
  logic [bah_pkg::SQ_OUT_W-1:0] acc_r;

  logic [23:0] mh;
  logic [23:0] ml;
  logic [23:0] op_a;
  logic [23:0] op_b;
  logic [bah_pkg::SQ_OUT_W-1:0] term;

  assign mh = m_r[39:16];
  assign ml = {8'd0, m_r[15:0]};

  always_comb begin
    case (ph_r)
      PH_HH:   begin op_a = mh; op_b = mh; end
      PH_HL:   begin op_a = mh; op_b = ml; end
      default: begin op_a = ml; op_b = ml; end
    endcase
  end

  always_comb begin
    case (pph_r)
      PH_HH:   term = {prod_r, 16'd0};
      PH_HL:   term = {15'd0, prod_r, 1'b0};
      default: term = {32'd0, prod_r[47:16]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= PH_HH;
      pph_r  <= PH_HH;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        iss_r <= 1'b1;
        pv_r  <= 1'b0;
        ph_r  <= PH_HH;
      end else begin
        pv_r  <= iss_r;
        pph_r <= ph_r;
        if (iss_r) begin
          ph_r <= ph_r + 2'd1;
          if (ph_r == PH_LL) begin
            iss_r <= 1'b0;
          end
        end
        if (pv_r && pph_r == PH_LL) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r   <= m;
      acc_r <= '0;
    end else begin
      if (iss_r) begin
        prod_r <= op_a * op_b;
      end
      if (pv_r) begin
        acc_r <= acc_r + term;
      end
    end
  end

  assign sts.busy = iss_r | pv_r;
  assign sts.done = done_r;
  assign sq       = acc_r;

endmodule

@@ rtl/core/bah_sqrt.sv @@
// ----------------------------------------------------------------------------
// bah_sqrt
// floor(sqrt(x * 2^16)), one root bit per cycle by digit pairs.
// ----------------------------------------------------------------------------
module bah_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bah_pkg::RT_IN_W-1:0]   x,
  output bah_pkg::unit_sts_t            sts,
  output logic [bah_pkg::RT_OUT_W-1:0]  root
);

  localparam int XS_W  = bah_pkg::RT_IN_W + 16;
  localparam int REM_W = bah_pkg::RT_OUT_W + 4;
  localparam int CNT_W = $clog2(bah_pkg::RT_OUT_W + 1);

  logic [XS_W-1:0]              xs_r;
  logic [REM_W-1:0]             rem_r;
  logic [bah_pkg::RT_OUT_W-1:0] root_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r;
  logic                         done_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;

  assign rem_sh = {rem_r[REM_W-3:0], xs_r[XS_W-1:XS_W-2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(bah_pkg::RT_OUT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs_r   <= {x, 16'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      xs_r   <= {xs_r[XS_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[bah_pkg::RT_OUT_W-2:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = root_r;

endmodule

@@ rtl/core/block_averaged_histogram.sv @@
// ----------------------------------------------------------------------------
// block_averaged_histogram
// Q16.16 histogram with block averaging and standard error per bin.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_stall is low only while the sequencer
// waits for an item. A sample by bin number reads its bin and writes it back,
// or is dropped when the bin is not in use. A sample by position takes a
// subtract and 32x32 multiply, then a read-modify-write of the bin memory, or
// is dropped when out of range with clamping off. A block close walks all
// MAX_BINS bins, each with a read, a divide on the serial divider, a square
// (skipped when the block value is too large to square) and a write. A finish
// walks every bin: three divides, a square and a square root per active bin
// with blocks, a read and an output per active bin with no blocks, a clear
// for each inactive bin, plus a block close when one is due. After reset a
// clearing pass over all MAX_BINS bins runs before the first item is taken.
// The finish results leave through an output register.
// ----------------------------------------------------------------------------
module block_averaged_histogram #(
  parameter int MAX_BINS = bah_pkg::MAX_BINS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_func,
  input  logic signed [31:0]               in_position,
  input  logic [5:0]                       in_bin_select,
  input  logic signed [31:0]               in_weight,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [5:0]                       out_bin_number,
  output logic signed [47:0]               out_bin_mean,
  output logic [46:0]                      out_bin_error,
  output logic [15:0]                      out_blocks_used,
  output logic                             out_tail_dropped,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bah_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bah_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int NB_W  = bah_pkg::NB_W;

  typedef enum logic [18:0] {
    ST_IDLE  = 19'h00001,
    ST_CLR   = 19'h00002,
    ST_LOC   = 19'h00004,
    ST_SBIN  = 19'h00008,
    ST_SWR   = 19'h00010,
    ST_CRD   = 19'h00020,
    ST_CDAT  = 19'h00040,
    ST_CDIV  = 19'h00080,
    ST_CSQ   = 19'h00100,
    ST_CWR   = 19'h00200,
    ST_FRD   = 19'h00400,
    ST_FDAT  = 19'h00800,
    ST_FMEAN = 19'h01000,
    ST_FM2   = 19'h02000,
    ST_FMSQ  = 19'h04000,
    ST_FVAR  = 19'h08000,
    ST_FVN   = 19'h10000,
    ST_FSQRT = 19'h20000,
    ST_FOUT  = 19'h40000
  } state_t;

  // configuration
  logic [31:0]   start_r;
  logic [31:0]   invw_r;
  logic [6:0]    bins_r;
  logic [1:0]    mode_r;
  logic          clamp_r;
  logic [15:0]   fpb_r;

  // control
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [31:0]       fib_r, fib_nxt;
  logic [15:0]       nblk_r, nblk_nxt;
  logic              fin_r, fin_nxt;
  logic              tail_r, tail_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  bin_r, bin_nxt;

  // datapath
  logic [31:0]  pos_r;
  logic [31:0]  wt_r;
  logic         below_r;
  logic [31:0]  bhi_r;
  logic         neg_r;
  logic [47:0]  v_r;
  logic [63:0]  sq_r;
  logic [47:0]  mean_r;
  logic [47:0]  mag_r;
  logic [63:0]  m2_r;
  logic [63:0]  msq_r;
  logic [39:0]  err_r;

  // bin memories: {count, weight sum} and {value sum, square sum}
  logic [79:0]  mem_a [MAX_BINS];
  logic [111:0] mem_b [MAX_BINS];
  logic [79:0]  rd_a_r;
  logic [111:0] rd_b_r;
  logic         mem_we;
  logic         mem_re;
  logic [IDX_W-1:0] mem_addr;
  logic [79:0]  wa_data;
  logic [111:0] wb_data;

  // output register
  logic [5:0]   ob_num_r;
  logic [47:0]  ob_mean_r;
  logic [46:0]  ob_err_r;
  logic [15:0]  ob_blk_r;
  logic         ob_tail_r;
  logic         ob_last_r;
  logic         out_load;

  // arithmetic units
  logic                      div_start;
  logic [bah_pkg::DVD_W-1:0] div_dvd;
  logic [bah_pkg::DVS_W-1:0] div_dvs;
  bah_pkg::unit_sts_t        div_sts;
  logic [bah_pkg::DVD_W-1:0] div_q;
  logic                      sq_start;
  logic [bah_pkg::SQ_IN_W-1:0] sq_m;
  bah_pkg::unit_sts_t        sq_sts;
  logic [bah_pkg::SQ_OUT_W-1:0] sq_res;
  logic                      rt_start;
  bah_pkg::unit_sts_t        rt_sts;
  logic [bah_pkg::RT_OUT_W-1:0] rt_root;

  // combinational helpers
  logic             in_acc;
  logic [NB_W-1:0]  nb;
  logic [IDX_W-1:0] nbm1;
  logic             idx_end;
  logic [31:0]      loc_diff;
  logic [63:0]      loc_prod;
  logic             sb_keep;
  logic [IDX_W-1:0] sb_bin;
  logic [31:0]      rd_cnt;
  logic [47:0]      rd_ws;
  logic [47:0]      rd_vs;
  logic [63:0]      rd_ss;
  logic [31:0]      cnt_new;
  logic [47:0]      ws_new;
  logic [47:0]      cmag;
  logic [47:0]      cv;
  logic [47:0]      vs_new;
  logic [64:0]      ss_sum;
  logic [63:0]      ss_new;
  logic [63:0]      var_q;
  logic [31:0]      fib_inc;
  logic             out_free;

  // a sample leaves the block sums of its bin untouched
  function automatic logic [111:0] mem_b_keep(input logic [111:0] d);
    return d;
  endfunction

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    if (bins_r == '0) begin
      nb = NB_W'(1);
    end else if (bins_r > NB_W'(MAX_BINS)) begin
      nb = NB_W'(MAX_BINS);
    end else begin
      nb = bins_r;
    end
  end

  assign nbm1    = IDX_W'(nb - NB_W'(1));
  assign idx_end = (idx_r == IDX_W'(MAX_BINS - 1));

  // position to bin: the difference is below 2^32 whenever it is not negative
  assign loc_diff = pos_r - start_r;
  assign loc_prod = loc_diff * invw_r;

  always_comb begin
    if (below_r) begin
      sb_keep = clamp_r;
      sb_bin  = '0;
    end else if (bhi_r >= {25'd0, nb}) begin
      sb_keep = clamp_r;
      sb_bin  = nbm1;
    end else begin
      sb_keep = 1'b1;
      sb_bin  = bhi_r[IDX_W-1:0];
    end
  end

  assign rd_cnt = rd_a_r[79:48];
  assign rd_ws  = rd_a_r[47:0];
  assign rd_vs  = rd_b_r[111:64];
  assign rd_ss  = rd_b_r[63:0];

  assign cnt_new = (mode_r != bah_pkg::MODE_WSUM && rd_cnt != '1) ? rd_cnt + 32'd1 : rd_cnt;
  assign ws_new  = (mode_r != bah_pkg::MODE_COUNT)
                 ? bah_pkg::sat48({rd_ws[47], rd_ws} + {{17{wt_r[31]}}, wt_r}) : rd_ws;

  // block value from the divider; count mode saturates at the 48-bit maximum
  assign cmag = (mode_r == bah_pkg::MODE_COUNT && div_q[47]) ? bah_pkg::S48MAX : div_q[47:0];
  assign cv   = neg_r ? (~cmag + 48'd1) : cmag;

  assign vs_new = bah_pkg::sat48({rd_vs[47], rd_vs} + {v_r[47], v_r});
  assign ss_sum = {1'b0, rd_ss} + {1'b0, sq_r};
  assign ss_new = ss_sum[64] ? '1 : ss_sum[63:0];
  assign var_q  = (m2_r > msq_r) ? (m2_r - msq_r) : '0;
  assign fib_inc = (fib_r != '1) ? fib_r + 32'd1 : fib_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    fib_nxt       = fib_r;
    nblk_nxt      = nblk_r;
    fin_nxt       = fin_r;
    tail_nxt      = tail_r;
    bin_nxt       = bin_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = idx_r;
    wa_data       = '0;
    wb_data       = '0;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;
    sq_start      = 1'b0;
    sq_m          = '0;
    rt_start      = 1'b0;
    out_load      = 1'b0;

    case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        if (idx_end) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            bah_pkg::FN_POS: state_nxt = ST_LOC;
            bah_pkg::FN_BIN: begin
              if ({1'b0, in_bin_select} < nb) begin
                mem_re    = 1'b1;
                mem_addr  = in_bin_select[IDX_W-1:0];
                bin_nxt   = in_bin_select[IDX_W-1:0];
                state_nxt = ST_SWR;
              end
            end
            bah_pkg::FN_EOF: begin
              fib_nxt = fib_inc;
              if (fib_inc == {16'd0, fpb_r}) begin
                fin_nxt   = 1'b0;
                idx_nxt   = '0;
                state_nxt = ST_CRD;
              end
            end
            default: begin
              idx_nxt = '0;
              if (fib_r != '0 && fib_r < {16'd0, fpb_r}) begin
                tail_nxt  = 1'b1;
                state_nxt = ST_FRD;
              end else if (fib_r != '0) begin
                tail_nxt  = 1'b0;
                fin_nxt   = 1'b1;
                state_nxt = ST_CRD;
              end else begin
                tail_nxt  = 1'b0;
                state_nxt = ST_FRD;
              end
            end
          endcase
        end
      end

      ST_LOC: state_nxt = ST_SBIN;

      ST_SBIN: begin
        if (sb_keep) begin
          mem_re    = 1'b1;
          mem_addr  = sb_bin;
          bin_nxt   = sb_bin;
          state_nxt = ST_SWR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_SWR: begin
        mem_we    = 1'b1;
        mem_addr  = bin_r;
        wa_data   = {cnt_new, ws_new};
        wb_data   = mem_b_keep(rd_b_r);
        state_nxt = ST_IDLE;
      end

      ST_CRD: begin
        mem_re    = 1'b1;
        state_nxt = ST_CDAT;
      end

      ST_CDAT: begin
        div_start = 1'b1;
        if (mode_r == bah_pkg::MODE_COUNT) begin
          div_dvd = {16'd0, rd_cnt, 16'd0};
          div_dvs = fib_r;
        end else begin
          div_dvd = {16'd0, bah_pkg::mag48(rd_ws)};
          div_dvs = (rd_cnt != '0) ? rd_cnt : fib_r;
        end
        state_nxt = ST_CDIV;
      end

      ST_CDIV: begin
        if (div_sts.done) begin
          if (cmag[47:40] != '0) begin
            state_nxt = ST_CWR;
          end else begin
            sq_start  = 1'b1;
            sq_m      = cmag[39:0];
            state_nxt = ST_CSQ;
          end
        end
      end

      ST_CSQ: begin
        if (sq_sts.done) begin
          state_nxt = ST_CWR;
        end
      end

      ST_CWR: begin
        mem_we  = 1'b1;
        wb_data = {vs_new, ss_new};
        if (idx_end) begin
          idx_nxt   = '0;
          fib_nxt   = '0;
          nblk_nxt  = (nblk_r != '1) ? nblk_r + 16'd1 : nblk_r;
          state_nxt = fin_r ? ST_FRD : ST_IDLE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_CRD;
        end
      end

      ST_FRD: begin
        if ({1'b0, idx_r} < nb) begin
          mem_re    = 1'b1;
          state_nxt = ST_FDAT;
        end else begin
          mem_we = 1'b1;
          if (idx_end) begin
            idx_nxt   = '0;
            fib_nxt   = '0;
            nblk_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      ST_FDAT: begin
        if (nblk_r == '0) begin
          state_nxt = ST_FOUT;
        end else begin
          div_start = 1'b1;
          div_dvd   = {16'd0, bah_pkg::mag48(rd_vs)};
          div_dvs   = {16'd0, nblk_r};
          state_nxt = ST_FMEAN;
        end
      end

      ST_FMEAN: begin
        if (div_sts.done) begin
          div_start = 1'b1;
          div_dvd   = rd_ss;
          div_dvs   = {16'd0, nblk_r};
          state_nxt = ST_FM2;
        end
      end

      ST_FM2: begin
        if (div_sts.done) begin
          if (mag_r[47:40] != '0) begin
            state_nxt = ST_FVAR;
          end else begin
            sq_start  = 1'b1;
            sq_m      = mag_r[39:0];
            state_nxt = ST_FMSQ;
          end
        end
      end

      ST_FMSQ: begin
        if (sq_sts.done) begin
          state_nxt = ST_FVAR;
        end
      end

      ST_FVAR: begin
        div_start = 1'b1;
        div_dvd   = var_q;
        div_dvs   = {16'd0, nblk_r};
        state_nxt = ST_FVN;
      end

      ST_FVN: begin
        if (div_sts.done) begin
          rt_start  = 1'b1;
          state_nxt = ST_FSQRT;
        end
      end

      ST_FSQRT: begin
        if (rt_sts.done) begin
          state_nxt = ST_FOUT;
        end
      end

      ST_FOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          mem_we   = 1'b1;
          if (idx_end) begin
            idx_nxt   = '0;
            fib_nxt   = '0;
            nblk_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_FRD;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      idx_r       <= '0;
      fib_r       <= '0;
      nblk_r      <= '0;
      fin_r       <= 1'b0;
      tail_r      <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      invw_r      <= 32'd65536;
      bins_r      <= 7'd64;
      mode_r      <= bah_pkg::MODE_COUNT;
      clamp_r     <= 1'b0;
      fpb_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      fib_r       <= fib_nxt;
      nblk_r      <= nblk_nxt;
      fin_r       <= fin_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          bah_pkg::CFG_RANGE_START:    start_r <= cfg_data;
          bah_pkg::CFG_INVERSE_WIDTH:  invw_r  <= cfg_data;
          bah_pkg::CFG_BINS_IN_USE:    bins_r  <= cfg_data[6:0];
          bah_pkg::CFG_HIST_MODE:      mode_r  <= cfg_data[1:0];
          bah_pkg::CFG_CLAMP_OUTSIDE:  clamp_r <= cfg_data[0];
          bah_pkg::CFG_FRAMES_PER_BLK: fpb_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    if (in_acc) begin
      pos_r <= in_position;
      wt_r  <= in_weight;
    end
    if (state_r == ST_LOC) begin
      below_r <= $signed(pos_r) < $signed(start_r);
      bhi_r   <= loc_prod[63:32];
    end
    if (state_r == ST_CDAT) begin
      neg_r <= (mode_r != bah_pkg::MODE_COUNT) && rd_ws[47];
    end
    if (state_r == ST_CDIV && div_sts.done) begin
      v_r <= cv;
      if (cmag[47:40] != '0) begin
        sq_r <= '1;
      end
    end
    if (state_r == ST_CSQ && sq_sts.done) begin
      sq_r <= sq_res;
    end
    if (state_r == ST_FDAT) begin
      neg_r  <= rd_vs[47];
      mean_r <= '0;
      err_r  <= '0;
    end
    if (state_r == ST_FMEAN && div_sts.done) begin
      mag_r  <= div_q[47:0];
      mean_r <= neg_r ? (~div_q[47:0] + 48'd1) : div_q[47:0];
    end
    if (state_r == ST_FM2 && div_sts.done) begin
      m2_r <= div_q;
      if (mag_r[47:40] != '0) begin
        msq_r <= '1;
      end
    end
    if (state_r == ST_FMSQ && sq_sts.done) begin
      msq_r <= sq_res;
    end
    if (state_r == ST_FSQRT && rt_sts.done) begin
      err_r <= rt_root;
    end
    if (out_load) begin
      ob_num_r  <= 6'(idx_r);
      ob_mean_r <= mean_r;
      ob_err_r  <= {7'd0, err_r};
      ob_blk_r  <= nblk_r;
      ob_tail_r <= tail_r;
      ob_last_r <= (idx_r == nbm1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_a_r <= mem_a[mem_addr];
      rd_b_r <= mem_b[mem_addr];
    end
    if (mem_we) begin
      mem_a[mem_addr] <= wa_data;
      mem_b[mem_addr] <= wb_data;
    end
  end

  bah_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .sts      (div_sts),
    .quotient (div_q)
  );

  bah_sq u_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .m     (sq_m),
    .sts   (sq_sts),
    .sq    (sq_res)
  );

  bah_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rt_start),
    .x     (div_q),
    .sts   (rt_sts),
    .root  (rt_root)
  );

  assign out_valid        = out_valid_r;
  assign out_bin_number   = ob_num_r;
  assign out_bin_mean     = ob_mean_r;
  assign out_bin_error    = ob_err_r;
  assign out_blocks_used  = ob_blk_r;
  assign out_tail_dropped = ob_tail_r;
  assign out_last         = ob_last_r;

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_out_from_fout: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FOUT))
    else $error("result loaded outside the output step");

  a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("bin memory read and written in one cycle");

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!div_sts.busy && !sq_sts.busy && !rt_sts.busy))
    else $error("arithmetic unit busy while idle");

endmodule
